// ===== src/mlfq_pkg.sv =====
// Shared constants, types and helpers for the multilevel feedback queue scheduler.
package mlfq_pkg;

  localparam int MAX_PROCS_DEF  = 16;
  localparam int MAX_CYCLES_DEF = 8;
  localparam int BURST_WIDTH    = 16;
  localparam int TIME_WIDTH     = 16;
  localparam int QUANT_WIDTH    = 8;
  localparam int ID_WIDTH       = 5;
  localparam int CFG_IDX_WIDTH  = 2;

  localparam logic [QUANT_WIDTH-1:0] Q0_RESET = 8'd2;
  localparam logic [QUANT_WIDTH-1:0] Q1_RESET = 8'd6;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_Q0 = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_Q1 = 2'd1;

  // queue levels
  localparam logic [1:0] LVL_RR0  = 2'd0;
  localparam logic [1:0] LVL_RR1  = 2'd1;
  localparam logic [1:0] LVL_SRT  = 2'd2;
  localparam logic [1:0] LVL_FCFS = 2'd3;

  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_BURST  = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_EMPTY    = 3'd0,
    ST_WAITING  = 3'd1,
    ST_READY    = 3'd2,
    ST_RUNNING  = 3'd3,
    ST_SLEEPING = 3'd4,
    ST_DONE     = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WAKE_RD,
    S_WAKE_CHK,
    S_ARR,
    S_SCHED,
    S_Q2_BND,
    S_Q2_BCAP,
    S_Q2_RD,
    S_Q2_CHK,
    S_Q2_END,
    S_EMIT,
    S_CNT_RD,
    S_CNT_CHK,
    S_RUN_RD,
    S_RUN_WR
  } state_t;

  // a zero slice acts as one tick
  function automatic logic [QUANT_WIDTH-1:0] fix_quantum(input logic [QUANT_WIDTH-1:0] q);
    fix_quantum = (q == '0) ? QUANT_WIDTH'(1) : q;
  endfunction

endpackage

// ===== src/mlfq_if.sv =====
// Channel interfaces: input items, result items and register writes.
interface mlfq_in_if;
  import mlfq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            operation;
  logic [ID_WIDTH-1:0]   process_id;
  logic [1:0]            initial_level;
  logic [TIME_WIDTH-1:0] arrival_time;
  logic [3:0]            cycle_count;
  logic [3:0]            burst_index;
  logic [BURST_WIDTH-1:0] burst_length;
  modport source (output valid, operation, process_id, initial_level, arrival_time,
                  cycle_count, burst_index, burst_length, input ready);
  modport sink   (input valid, operation, process_id, initial_level, arrival_time,
                  cycle_count, burst_index, burst_length, output ready);
endinterface

interface mlfq_out_if;
  import mlfq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] tick_time;
  logic [ID_WIDTH-1:0]   running_id;
  logic                  switched;
  logic                  all_done;
  modport source (output valid, tick_time, running_id, switched, all_done, input ready);
  modport sink   (input valid, tick_time, running_id, switched, all_done, output ready);
endinterface

interface mlfq_cfg_if;
  import mlfq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_WIDTH-1:0] index;
  logic [QUANT_WIDTH-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/multilevel_feedback_queue_scheduler.sv =====
// Top level of the multilevel feedback queue scheduler.
//
// Load items (header, burst) are taken while idle and give no result. A tick item
// walks the process slots with one shared slot index: wakeup scan (every slot,
// with a burst read for each sleeper), arrival scan (every slot, only while
// arrivals are pending), the scheduling step, a shortest-remaining scan when Q2 is
// consulted (every slot with a read per Q2 member, plus a bound read of the running
// burst when a Q2 process runs), the report step that posts the result, a countdown
// scan (every slot, with a read per sleeper) and a read and write of the running
// burst when one runs. The length of a tick is set by the single read port of the
// burst memory and the slot-by-slot scans. A tick that reports all_done stops after
// posting its result. The result register must be emptied before the next item is
// taken. There is no clearing pass: burst memory content is valid once loaded.
module multilevel_feedback_queue_scheduler
  import mlfq_pkg::*;
#(
  parameter int MAX_PROCS  = MAX_PROCS_DEF,
  parameter int MAX_CYCLES = MAX_CYCLES_DEF
) (
  input logic        clk,
  input logic        rst,
  mlfq_in_if.sink    in_ch,
  mlfq_out_if.source out_ch,
  mlfq_cfg_if.sink   cfg_ch
);
  import mlfq_pkg::*;

  localparam int SLOT_W      = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int BURST_SLOTS = 2 * MAX_CYCLES - 1;
  localparam int POS_W       = $clog2(2 * MAX_CYCLES);
  localparam int CYC_W       = $clog2(MAX_CYCLES + 1);
  localparam int DEPTH       = MAX_PROCS * BURST_SLOTS;
  localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // per-slot state, one shared read index
  status_t                status_q [MAX_PROCS];
  logic [1:0]             level_q  [MAX_PROCS];
  logic [POS_W-1:0]       pos_q    [MAX_PROCS];
  logic [TIME_WIDTH-1:0]  arr_q    [MAX_PROCS];
  logic [CYC_W-1:0]       cyc_q    [MAX_PROCS];
  logic [MAX_PROCS-1:0]   members;

  state_t                 state;
  state_t                 state_next;
  logic [SLOT_W-1:0]      idx;
  logic                   run_v;
  logic [SLOT_W-1:0]      run_slot;
  logic [1:0]             run_level;
  logic [QUANT_WIDTH-1:0] quantum;
  logic [TIME_WIDTH-1:0]  cur_time;
  logic [ID_WIDTH-1:0]    prev_id;
  logic                   pending;
  logic                   sleep_any;
  logic                   arr_any;
  logic                   done_f;
  logic                   bounded;
  logic                   found_v;
  logic [SLOT_W-1:0]      found;
  logic [BURST_WIDTH-1:0] best;
  logic                   have;
  logic [QUANT_WIDTH-1:0] q0_quant;
  logic [QUANT_WIDTH-1:0] q1_quant;

  logic                   out_valid;
  logic [TIME_WIDTH-1:0]  out_time;
  logic [ID_WIDTH-1:0]    out_id;
  logic                   out_sw;
  logic                   out_done;

  logic                   in_fire;
  logic                   id_ok;
  logic [SLOT_W-1:0]      ld_slot;
  logic [SLOT_W-1:0]      sel;
  logic [POS_W-1:0]       pos_c;
  logic [AW-1:0]          cur_addr;
  logic [AW-1:0]          ld_addr;
  logic                   last;
  logic                   hdr_ok;
  logic                   burst_ok;
  logic [CYC_W-1:0]       cyc_in;
  logic [3:0]             cyc_fix;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [BURST_WIDTH-1:0] ram_wdata;
  logic [BURST_WIDTH-1:0] rdata;
  logic [BURST_WIDTH-1:0] r_dec;
  logic [QUANT_WIDTH-1:0] q_dec;
  logic                   run_end;
  logic                   run_demote;
  logic                   proc_fin;

  logic                   enq_v;
  logic [SLOT_W-1:0]      enq_slot;
  logic [1:0]             enq_lvl;

  logic                   q0_pop, q1_pop, q3_pop;
  logic                   q0_empty, q1_empty, q3_empty;
  logic [SLOT_W-1:0]      q0_head, q1_head, q3_head;
  logic                   arr_hit;
  logic [ID_WIDTH-1:0]    shown;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = out_valid;
  assign out_ch.tick_time  = out_time;
  assign out_ch.running_id = out_id;
  assign out_ch.switched   = out_sw;
  assign out_ch.all_done   = out_done;

  // load decode
  assign id_ok   = (in_ch.process_id != '0) && (int'(in_ch.process_id) <= MAX_PROCS);
  assign ld_slot = SLOT_W'(in_ch.process_id - ID_WIDTH'(1));
  assign ld_addr = AW'(ld_slot) * AW'(BURST_SLOTS) + AW'(in_ch.burst_index);
  assign cyc_fix = (in_ch.cycle_count == '0) ? 4'd1 : in_ch.cycle_count;
  assign cyc_in  = (int'(cyc_fix) > MAX_CYCLES) ? CYC_W'(MAX_CYCLES) : CYC_W'(cyc_fix);

  always_comb begin
    case (state)
      S_IDLE:                       sel = ld_slot;
      S_Q2_BND, S_RUN_RD, S_RUN_WR: sel = run_slot;
      default:                      sel = idx;
    endcase
  end

  assign pos_c = (int'(pos_q[sel]) >= BURST_SLOTS) ? POS_W'(BURST_SLOTS - 1) : pos_q[sel];
  assign cur_addr = AW'(sel) * AW'(BURST_SLOTS) + AW'(pos_c);
  assign last = (idx == SLOT_W'(MAX_PROCS - 1));

  assign hdr_ok = in_fire && (in_ch.operation == OP_HEADER) && id_ok &&
                  (status_q[sel] inside {ST_EMPTY, ST_WAITING, ST_DONE});
  assign burst_ok = in_fire && (in_ch.operation == OP_BURST) && id_ok &&
                    (status_q[sel] == ST_WAITING) &&
                    (int'(in_ch.burst_index) < BURST_SLOTS);

  // running burst bookkeeping
  assign r_dec      = (rdata != '0) ? rdata - 1'b1 : '0;
  assign q_dec      = (quantum != '0) ? quantum - 1'b1 : '0;
  assign run_end    = (state == S_RUN_WR) && run_v && (r_dec == '0);
  assign run_demote = (state == S_RUN_WR) && run_v && (r_dec != '0) &&
                      (run_level < LVL_SRT) && (q_dec == '0);
  assign proc_fin   = (int'(pos_q[sel]) + 1 >= 2 * int'(cyc_q[sel]) - 1);
  assign arr_hit    = (status_q[sel] == ST_WAITING) && (arr_q[sel] == cur_time);

  // burst memory port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = r_dec;
    if (state == S_IDLE) begin
      ram_we    = burst_ok;
      ram_waddr = ld_addr;
      ram_wdata = (in_ch.burst_length == '0) ? BURST_WIDTH'(1) : in_ch.burst_length;
    end else if (state == S_CNT_CHK) begin
      ram_we = (rdata != '0);
    end else if (state == S_RUN_WR) begin
      ram_we = run_v;
    end
  end

  mlfq_burst_ram #(.DEPTH(DEPTH), .AW(AW), .DW(BURST_WIDTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur_addr),
    .rdata (rdata)
  );

  // at most one enqueue per cycle
  always_comb begin
    enq_v    = 1'b0;
    enq_slot = sel;
    enq_lvl  = level_q[sel];
    case (state)
      S_WAKE_CHK: begin
        enq_v   = (rdata == '0);
        enq_lvl = (level_q[sel] != LVL_RR0) ? level_q[sel] - 1'b1 : LVL_RR0;
      end
      S_ARR: begin
        enq_v = arr_hit;
      end
      S_Q2_END: begin
        enq_v    = found_v && bounded;
        enq_slot = run_slot;
        enq_lvl  = LVL_FCFS;
      end
      S_RUN_WR: begin
        enq_v    = run_demote;
        enq_slot = run_slot;
        enq_lvl  = run_level + 1'b1;
      end
      default: begin
        enq_v = 1'b0;
      end
    endcase
  end

  assign q0_pop = (state == S_SCHED) && !run_v && !q0_empty;
  assign q1_pop = (state == S_SCHED) && !run_v && q0_empty && !q1_empty;
  assign q3_pop = (state == S_SCHED) && !run_v && q0_empty && q1_empty &&
                  (members == '0) && !q3_empty;

  mlfq_fifo #(.DEPTH(MAX_PROCS), .W(SLOT_W)) u_q0 (
    .clk(clk), .rst(rst), .push(enq_v && (enq_lvl == LVL_RR0)), .push_data(enq_slot),
    .pop(q0_pop), .head_data(q0_head), .empty(q0_empty)
  );
  mlfq_fifo #(.DEPTH(MAX_PROCS), .W(SLOT_W)) u_q1 (
    .clk(clk), .rst(rst), .push(enq_v && (enq_lvl == LVL_RR1)), .push_data(enq_slot),
    .pop(q1_pop), .head_data(q1_head), .empty(q1_empty)
  );
  mlfq_fifo #(.DEPTH(MAX_PROCS), .W(SLOT_W)) u_q3 (
    .clk(clk), .rst(rst), .push(enq_v && (enq_lvl == LVL_FCFS)), .push_data(enq_slot),
    .pop(q3_pop), .head_data(q3_head), .empty(q3_empty)
  );

  // per-slot table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PROCS; i++) begin
        status_q[i] <= ST_EMPTY;
        pos_q[i]    <= '0;
      end
      members <= '0;
    end else begin
      if (enq_v) begin
        status_q[enq_slot] <= ST_READY;
        if (enq_lvl == LVL_SRT) begin
          members[enq_slot] <= 1'b1;
        end
      end
      case (state)
        S_IDLE: begin
          if (hdr_ok) begin
            level_q[sel]  <= in_ch.initial_level;
            arr_q[sel]    <= in_ch.arrival_time;
            cyc_q[sel]    <= cyc_in;
            pos_q[sel]    <= '0;
            status_q[sel] <= ST_WAITING;
          end
        end
        S_WAKE_CHK: begin
          if (rdata == '0) begin
            pos_q[sel]   <= pos_q[sel] + 1'b1;
            level_q[sel] <= enq_lvl;
          end
        end
        S_SCHED: begin
          if (q0_pop) status_q[q0_head] <= ST_RUNNING;
          if (q1_pop) status_q[q1_head] <= ST_RUNNING;
          if (q3_pop) status_q[q3_head] <= ST_RUNNING;
        end
        S_Q2_END: begin
          if (found_v) begin
            members[found]  <= 1'b0;
            status_q[found] <= ST_RUNNING;
            if (bounded) begin
              level_q[run_slot] <= LVL_FCFS;
            end
          end
        end
        S_RUN_WR: begin
          if (run_end) begin
            pos_q[sel]    <= pos_q[sel] + 1'b1;
            status_q[sel] <= proc_fin ? ST_DONE : ST_SLEEPING;
          end else if (run_demote) begin
            level_q[sel] <= enq_lvl;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_fire && (in_ch.operation == OP_TICK)) state_next = S_WAKE_RD;
      S_WAKE_RD: begin
        if (status_q[sel] == ST_SLEEPING) state_next = S_WAKE_CHK;
        else if (last) state_next = pending ? S_ARR : S_SCHED;
      end
      S_WAKE_CHK: state_next = last ? (pending ? S_ARR : S_SCHED) : S_WAKE_RD;
      S_ARR:      if (last) state_next = S_SCHED;
      S_SCHED: begin
        if (!run_v && q0_empty && q1_empty && (members != '0)) state_next = S_Q2_RD;
        else if (run_v && (run_level == LVL_SRT)) state_next = S_Q2_BND;
        else state_next = S_EMIT;
      end
      S_Q2_BND:   state_next = S_Q2_BCAP;
      S_Q2_BCAP:  state_next = S_Q2_RD;
      S_Q2_RD: begin
        if (members[idx]) state_next = S_Q2_CHK;
        else if (last) state_next = S_Q2_END;
      end
      S_Q2_CHK:   state_next = last ? S_Q2_END : S_Q2_RD;
      S_Q2_END:   state_next = S_EMIT;
      S_EMIT:     state_next = done_f ? S_IDLE : S_CNT_RD;
      S_CNT_RD: begin
        if (status_q[sel] == ST_SLEEPING) state_next = S_CNT_CHK;
        else if (last) state_next = S_RUN_RD;
      end
      S_CNT_CHK:  state_next = last ? S_RUN_RD : S_CNT_RD;
      S_RUN_RD:   state_next = run_v ? S_RUN_WR : S_IDLE;
      S_RUN_WR:   state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign shown = run_v ? ID_WIDTH'(run_slot + 1'b1) : '0;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      run_v     <= 1'b0;
      run_slot  <= '0;
      run_level <= LVL_RR0;
      quantum   <= '0;
      cur_time  <= '0;
      prev_id   <= '0;
      pending   <= 1'b1;
      sleep_any <= 1'b0;
      arr_any   <= 1'b0;
      done_f    <= 1'b0;
      bounded   <= 1'b0;
      found_v   <= 1'b0;
      found     <= '0;
      have      <= 1'b0;
      q0_quant  <= Q0_RESET;
      q1_quant  <= Q1_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_Q0) q0_quant <= cfg_ch.data;
        else if (cfg_ch.index == CFG_Q1) q1_quant <= cfg_ch.data;
      end
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          idx <= '0;
          if (hdr_ok) pending <= 1'b1;
          sleep_any <= 1'b0;
          arr_any   <= 1'b0;
          done_f    <= 1'b0;
        end
        S_WAKE_RD: begin
          if (status_q[sel] != ST_SLEEPING) idx <= last ? '0 : idx + 1'b1;
        end
        S_WAKE_CHK: begin
          if (rdata != '0) sleep_any <= 1'b1;
          idx <= last ? '0 : idx + 1'b1;
        end
        S_ARR: begin
          if ((status_q[sel] == ST_WAITING) && !arr_hit) arr_any <= 1'b1;
          if (last) begin
            pending <= arr_any || ((status_q[sel] == ST_WAITING) && !arr_hit);
          end
          idx <= last ? '0 : idx + 1'b1;
        end
        S_SCHED: begin
          idx     <= '0;
          found_v <= 1'b0;
          if (!run_v) begin
            bounded <= 1'b0;
            have    <= 1'b0;
            if (!q0_empty) begin
              run_v     <= 1'b1;
              run_slot  <= q0_head;
              run_level <= LVL_RR0;
              quantum   <= fix_quantum(q0_quant);
            end else if (!q1_empty) begin
              run_v     <= 1'b1;
              run_slot  <= q1_head;
              run_level <= LVL_RR1;
              quantum   <= fix_quantum(q1_quant);
            end else if (members == '0) begin
              if (!q3_empty) begin
                run_v     <= 1'b1;
                run_slot  <= q3_head;
                run_level <= LVL_FCFS;
                quantum   <= QUANT_WIDTH'(1);
              end else begin
                done_f <= !pending && !sleep_any;
              end
            end
          end else begin
            bounded <= 1'b1;
          end
        end
        S_Q2_BCAP: begin
          best <= rdata;
          have <= 1'b1;
        end
        S_Q2_RD: begin
          if (!members[idx]) idx <= last ? '0 : idx + 1'b1;
        end
        S_Q2_CHK: begin
          // strict compare keeps the lowest id on a tie
          if (!have || (rdata < best)) begin
            have    <= 1'b1;
            best    <= rdata;
            found   <= idx;
            found_v <= 1'b1;
          end
          idx <= last ? '0 : idx + 1'b1;
        end
        S_Q2_END: begin
          if (found_v) begin
            run_slot  <= found;
            run_level <= LVL_SRT;
            if (!bounded) begin
              run_v   <= 1'b1;
              quantum <= QUANT_WIDTH'(1);
            end
          end
        end
        S_EMIT: begin
          out_valid <= 1'b1;
          out_time  <= cur_time;
          out_id    <= shown;
          out_sw    <= (shown != prev_id);
          out_done  <= done_f;
          prev_id   <= shown;
          idx       <= '0;
          if (!done_f) cur_time <= cur_time + 1'b1;
        end
        S_CNT_RD: begin
          if (status_q[sel] != ST_SLEEPING) idx <= last ? '0 : idx + 1'b1;
        end
        S_CNT_CHK: begin
          idx <= last ? '0 : idx + 1'b1;
        end
        S_RUN_WR: begin
          if (run_end || run_demote) begin
            run_v <= 1'b0;
          end else if (run_v && (run_level < LVL_SRT)) begin
            quantum <= q_dec;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result only appears right after the report step of a tick
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EMIT)
    else $error("result posted outside report step");

  // between items the running process is marked running in the slot table
  a_run_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && run_v) |-> status_q[run_slot] == ST_RUNNING)
    else $error("running slot not in running status");

  // the running process is never also waiting in the shortest-remaining set
  a_run_not_member: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && run_v) |-> !members[run_slot])
    else $error("running slot still in Q2 set");
`endif

endmodule

// ===== src/mlfq_burst_ram.sv =====
// Burst length memory: one write port, one read port with registered data.
module mlfq_burst_ram #(
  parameter int DEPTH = 240,
  parameter int AW    = 8,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/mlfq_fifo.sv =====
// Ready queue of process slots, circular buffer; a push to a full queue is dropped.
module mlfq_fifo #(
  parameter int DEPTH = 16,
  parameter int W     = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head_data,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign empty     = (count == '0);
  assign head_data = mem[head];
  assign do_push   = push && (count != CW'(DEPTH));
  assign do_pop    = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == PW'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (do_pop) begin
        head <= (head == PW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ===== sim/tb_multilevel_feedback_queue_scheduler.sv =====
// Self-checking testbench for the multilevel feedback queue scheduler.
module tb_multilevel_feedback_queue_scheduler;
  import mlfq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         NPROC      = 16;
  localparam int         NBURST     = 15;      // 2*MAX_CYCLES-1 burst slots per process
  localparam int         NO_SLOT    = NPROC;
  localparam logic [1:0] OP_UNUSED  = 2'd3;    // undefined operation, must be ignored
  localparam int         TARGET     = 1750;    // input items to send
  localparam int         DRAIN      = 200;     // cycles, covers the slowest tick
  localparam int         STALL_LIM  = 20000;   // cycles with no handshake at all

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  id;
    logic [1:0]  lvl;
    logic [15:0] arr;
    logic [3:0]  cnt;
    logic [3:0]  bi;
    logic [15:0] len;
  } sched_item_t;

  typedef struct packed {
    logic [15:0] t;
    logic [4:0]  rid;
    logic        sw;
    logic        dn;
  } report_t;

  typedef struct packed {
    sched_item_t it;
    logic        typed;   // expected report written out by hand
    report_t     want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mlfq_in_if  in_ch();
  mlfq_out_if out_ch();
  mlfq_cfg_if cfg_ch();

  multilevel_feedback_queue_scheduler dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scheduler predictor: own copy of every process table, queue and register.
  // ---------------------------------------------------------------------------
  logic [15:0] burst_mem [NPROC][NBURST];
  int          burst_pos [NPROC];
  logic [15:0] arrive_at [NPROC];
  int          cpu_cycles [NPROC];
  logic [1:0]  proc_lvl [NPROC];
  status_t     proc_st [NPROC];
  int          rr0_q[$], rr1_q[$], fcfs_q[$];
  bit          srt_set [NPROC];
  int          run_slot, run_lvl, slice_left, last_shown;
  logic [15:0] sim_now;
  bit          arrivals_open;
  logic [7:0]  slice0, slice1;

  report_t pending_reports[$];
  int      n_items, n_reports, n_done_reports, n_finished, n_cfg, n_errors;
  int      send_idle_pct, recv_stall_pct;

  function automatic void sched_clear();
    for (int i = 0; i < NPROC; i++) begin
      burst_pos[i] = 0;
      proc_st[i] = ST_EMPTY;
      srt_set[i] = 1'b0;
      cpu_cycles[i] = 0;
      proc_lvl[i] = LVL_RR0;
      arrive_at[i] = '0;
      for (int j = 0; j < NBURST; j++) burst_mem[i][j] = '0;
    end
    rr0_q.delete();
    rr1_q.delete();
    fcfs_q.delete();
    run_slot = NO_SLOT;
    run_lvl = 0;
    slice_left = 0;
    last_shown = 0;
    sim_now = '0;
    arrivals_open = 1'b1;
    slice0 = Q0_RESET;
    slice1 = Q1_RESET;
  endfunction

  // current burst of a slot, position saturates at the last one
  function automatic int cur_burst(int s);
    return (burst_pos[s] >= NBURST) ? NBURST - 1 : burst_pos[s];
  endfunction

  function automatic void make_ready(int s);
    proc_st[s] = ST_READY;
    case (proc_lvl[s])
      LVL_RR0: rr0_q.push_back(s);
      LVL_RR1: rr1_q.push_back(s);
      LVL_SRT: srt_set[s] = 1'b1;
      default: fcfs_q.push_back(s);
    endcase
  endfunction

  // shortest remaining Q2 member, lowest slot wins a tie; bounded: strictly below
  function automatic int srt_take(bit bounded, int bound);
    int  found;
    int  best;
    bit  have;
    int  t;
    found = NO_SLOT;
    best = bound;
    have = bounded;
    for (int i = 0; i < NPROC; i++) begin
      if (srt_set[i]) begin
        t = burst_mem[i][cur_burst(i)];
        if (!have || t < best) begin
          have = 1'b1;
          best = t;
          found = i;
        end
      end
    end
    if (found != NO_SLOT) srt_set[found] = 1'b0;
    return found;
  endfunction

  function automatic void dispatch(int s, int slice);
    run_slot = s;
    run_lvl = proc_lvl[s];
    proc_st[s] = ST_RUNNING;
    slice_left = (slice == 0) ? 1 : slice;
  endfunction

  // returns 1 when the item yields a report
  function automatic bit sched_predict(input sched_item_t it, output report_t r);
    int  s;
    int  c;
    int  a;
    int  rem;
    int  shown;
    bit  waiting_left;
    bit  sleeping;
    bit  done;
    r = '0;
    done = 1'b0;
    if (it.op == OP_HEADER || it.op == OP_BURST) begin
      if (it.id == 0 || it.id > NPROC) return 1'b0;
      s = it.id - 1;
      if (it.op == OP_HEADER) begin
        // busy slot: ready, running or sleeping keeps its header
        if (proc_st[s] != ST_EMPTY && proc_st[s] != ST_WAITING && proc_st[s] != ST_DONE)
          return 1'b0;
        c = it.cnt;
        if (c == 0) c = 1;
        if (c > MAX_CYCLES_DEF) c = MAX_CYCLES_DEF;
        proc_lvl[s] = it.lvl;
        arrive_at[s] = it.arr;
        cpu_cycles[s] = c;
        burst_pos[s] = 0;
        proc_st[s] = ST_WAITING;
        arrivals_open = 1'b1;
      end else if (proc_st[s] == ST_WAITING && it.bi < NBURST) begin
        burst_mem[s][it.bi] = (it.len == 0) ? 16'd1 : it.len;
      end
      return 1'b0;
    end
    if (it.op != OP_TICK) return 1'b0;

    // sleepers whose I/O ran out wake one level up
    for (int i = 0; i < NPROC; i++) begin
      if (proc_st[i] == ST_SLEEPING && burst_mem[i][cur_burst(i)] == 0) begin
        burst_pos[i]++;
        if (proc_lvl[i] != LVL_RR0) proc_lvl[i] = proc_lvl[i] - 2'd1;
        make_ready(i);
      end
    end

    if (arrivals_open) begin
      waiting_left = 1'b0;
      for (int i = 0; i < NPROC; i++) begin
        if (proc_st[i] == ST_WAITING) begin
          if (arrive_at[i] == sim_now) make_ready(i);
          else waiting_left = 1'b1;
        end
      end
      if (!waiting_left) arrivals_open = 1'b0;
    end

    if (run_slot == NO_SLOT) begin
      if (rr0_q.size() > 0) dispatch(rr0_q.pop_front(), slice0);
      else if (rr1_q.size() > 0) dispatch(rr1_q.pop_front(), slice1);
      else begin
        s = srt_take(1'b0, 0);
        if (s != NO_SLOT) dispatch(s, 1);
        else if (fcfs_q.size() > 0) dispatch(fcfs_q.pop_front(), 1);
        else begin
          sleeping = 1'b0;
          for (int i = 0; i < NPROC; i++) if (proc_st[i] == ST_SLEEPING) sleeping = 1'b1;
          done = !arrivals_open && !sleeping;
        end
      end
    end else if (run_lvl == LVL_SRT) begin
      // a strictly shorter Q2 entry preempts; the loser drops to FCFS
      s = srt_take(1'b1, burst_mem[run_slot][cur_burst(run_slot)]);
      if (s != NO_SLOT) begin
        proc_lvl[run_slot] = LVL_FCFS;
        make_ready(run_slot);
        run_slot = s;
        run_lvl = LVL_SRT;
        proc_st[s] = ST_RUNNING;
      end
    end

    shown = (run_slot == NO_SLOT) ? 0 : run_slot + 1;
    r.t = sim_now;
    r.rid = shown;
    r.sw = (shown != last_shown);
    r.dn = done;
    last_shown = shown;
    if (done) return 1'b1;   // finished: time holds still

    sim_now = sim_now + 16'd1;
    for (int i = 0; i < NPROC; i++) begin
      a = cur_burst(i);
      if (proc_st[i] == ST_SLEEPING && burst_mem[i][a] > 0) burst_mem[i][a]--;
    end

    if (run_slot != NO_SLOT) begin
      s = run_slot;
      a = cur_burst(s);
      rem = (burst_mem[s][a] > 0) ? burst_mem[s][a] - 1 : 0;
      burst_mem[s][a] = rem;
      if (rem == 0) begin
        burst_pos[s]++;
        if (burst_pos[s] >= 2 * cpu_cycles[s] - 1) begin
          proc_st[s] = ST_DONE;
          n_finished++;
        end else begin
          proc_st[s] = ST_SLEEPING;
        end
        run_slot = NO_SLOT;
      end else if (run_lvl < LVL_SRT) begin
        if (slice_left > 0) slice_left--;
        if (slice_left == 0) begin
          proc_lvl[s] = run_lvl + 1;   // slice used up: demote one level
          make_ready(s);
          run_slot = NO_SLOT;
        end
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // valid stays high when the next item follows at once; it only drops for a gap
  task automatic send(input sched_item_t it, input bit typed, input report_t want,
                      output bit got, output report_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= it.op;
    in_ch.process_id    <= it.id;
    in_ch.initial_level <= it.lvl;
    in_ch.arrival_time  <= it.arr;
    in_ch.cycle_count   <= it.cnt;
    in_ch.burst_index   <= it.bi;
    in_ch.burst_length  <= it.len;
    do @(posedge clk); while (!in_ch.ready);
    n_items++;
    got = sched_predict(it, r);
    if (got) pending_reports.push_back(typed ? want : r);
  endtask

  task automatic tick(output bit got, output report_t r);
    sched_item_t it;
    it = '0;
    it.op = OP_TICK;
    send(it, 1'b0, '0, got, r);
  endtask

  task automatic load(input sched_item_t it);
    bit      got;
    report_t r;
    send(it, 1'b0, '0, got, r);
  endtask

  // pause the sender until every report is in and the block has gone quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_reports.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_Q0) slice0 = val;
    else slice1 = val;
    n_cfg++;
    @(posedge clk);
  endtask

  function automatic int pick_slot(bit want_free);
    int base;
    int s;
    bit free;
    base = $urandom_range(NPROC - 1);
    for (int k = 0; k < NPROC; k++) begin
      s = (base + k) % NPROC;
      free = (proc_st[s] == ST_EMPTY || proc_st[s] == ST_DONE);
      if (want_free ? free : (proc_st[s] == ST_READY || proc_st[s] == ST_RUNNING ||
                              proc_st[s] == ST_SLEEPING)) return s;
    end
    return NO_SLOT;
  endfunction

  // header plus its full burst list, so no unloaded burst is ever read
  task automatic add_process();
    sched_item_t it;
    int          s;
    int          c;
    int          k;
    s = pick_slot(1'b1);
    if (s == NO_SLOT) return;
    it = '0;
    it.op = OP_HEADER;
    it.id = s + 1;
    if ($urandom_range(7) == 0) begin
      // throwaway header with any arrival, possibly already past; replaced below
      it.arr = $urandom;
      it.cnt = $urandom;
      it.lvl = $urandom;
      load(it);
    end
    it.lvl = $urandom;
    it.arr = sim_now + 16'($urandom_range(10));
    it.cnt = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 4));
    load(it);
    c = (it.cnt == 0) ? 1 : (it.cnt > MAX_CYCLES_DEF) ? MAX_CYCLES_DEF : it.cnt;
    it.op = OP_BURST;
    for (int b = 0; b < 2 * c - 1; b++) begin
      it.bi = b;
      if ($urandom_range(7) == 0) begin
        it.len = $urandom;   // overwritten before arrival
        load(it);
      end
      k = $urandom_range(9);
      it.len = (k == 0) ? 16'd0 : (k == 1) ? 16'($urandom_range(9, 40))
                                            : 16'($urandom_range(1, 8));
      load(it);
    end
  endtask

  // items the block must drop without a report
  task automatic noise();
    sched_item_t it;
    int          s;
    it = $urandom;
    case ($urandom_range(4))
      0: it.op = OP_UNUSED;
      1: begin
        it.op = ($urandom_range(1) == 0) ? OP_HEADER : OP_BURST;
        it.id = ($urandom_range(1) == 0) ? 5'd0 : 5'($urandom_range(NPROC + 1, 31));
      end
      2: begin
        it.op = OP_BURST;
        it.bi = NBURST;
        it.id = $urandom_range(1, NPROC);
      end
      3: begin
        s = $urandom_range(NPROC - 1);
        it.op = (proc_st[s] == ST_WAITING) ? OP_UNUSED : OP_BURST;
        it.id = s + 1;
      end
      default: begin
        s = pick_slot(1'b0);
        it.op = (s == NO_SLOT) ? OP_UNUSED : OP_HEADER;
        it.id = s + 1;
      end
    endcase
    load(it);
  endtask

  // ---------------------------------------------------------------------------
  // Report checker and receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    report_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_reports++;
      if (out_ch.all_done) n_done_reports++;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report, actual time %0d id %0d", $time,
                 out_ch.tick_time, out_ch.running_id);
        n_errors++;
      end else begin
        e = pending_reports.pop_front();
        if (out_ch.tick_time !== e.t) begin
          $display("%0t: tick_time expected %0d actual %0d", $time, e.t, out_ch.tick_time);
          n_errors++;
        end
        if (out_ch.running_id !== e.rid) begin
          $display("%0t: running_id expected %0d actual %0d", $time, e.rid,
                   out_ch.running_id);
          n_errors++;
        end
        if (out_ch.switched !== e.sw) begin
          $display("%0t: switched expected %0d actual %0d", $time, e.sw, out_ch.switched);
          n_errors++;
        end
        if (out_ch.all_done !== e.dn) begin
          $display("%0t: all_done expected %0d actual %0d", $time, e.dn, out_ch.all_done);
          n_errors++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: no handshake on any channel for too long ends the run
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIM) begin
      $display("%0t: watchdog expired, %0d reports outstanding", $time,
               pending_reports.size());
      $display("multilevel_feedback_queue_scheduler regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  row_t dir_rows[24];

  initial begin
    bit      got;
    report_t r;
    int      cur_phase;
    int      phase;
    int      steps;

    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.process_id = '0;
    in_ch.initial_level = '0;
    in_ch.arrival_time = '0;
    in_ch.cycle_count = '0;
    in_ch.burst_index = '0;
    in_ch.burst_length = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_items = 0;
    n_reports = 0;
    n_done_reports = 0;
    n_finished = 0;
    n_cfg = 0;
    n_errors = 0;
    sched_clear();

    // directed: op, id, level, arrival, count, index, length | typed report
    dir_rows = '{
      // empty scheduler reports done at time zero right away
      '{'{OP_TICK,   5'd0,  2'd0, 16'd0,     4'd0,  4'd0,  16'd0},     1'b1,
        '{16'd0, 5'd0, 1'b0, 1'b1}},
      '{'{OP_UNUSED, 5'd5,  2'd3, 16'hFFFF,  4'hF,  4'hF,  16'hFFFF},  1'b0, '0},
      '{'{OP_HEADER, 5'd0,  2'd1, 16'd3,     4'd1,  4'd0,  16'd0},     1'b0, '0},
      '{'{OP_HEADER, 5'd31, 2'd3, 16'hFFFF,  4'hF,  4'hF,  16'hFFFF},  1'b0, '0},
      // slot 16 first gets extreme values, then a sane header replaces them
      '{'{OP_HEADER, 5'd16, 2'd3, 16'hFFFF,  4'hF,  4'd0,  16'd0},     1'b0, '0},
      '{'{OP_BURST,  5'd16, 2'd0, 16'd0,     4'd0,  4'hF,  16'd7},     1'b0, '0},
      '{'{OP_HEADER, 5'd16, 2'd3, 16'd2,     4'd0,  4'd0,  16'd0},     1'b0, '0},
      '{'{OP_BURST,  5'd16, 2'd0, 16'd0,     4'd0,  4'd0,  16'hFFFF},  1'b0, '0},
      '{'{OP_BURST,  5'd16, 2'd0, 16'd0,     4'd0,  4'd0,  16'd0},     1'b0, '0},
      '{'{OP_HEADER, 5'd1,  2'd0, 16'd1,     4'd2,  4'd0,  16'd0},     1'b0, '0},
      '{'{OP_BURST,  5'd1,  2'd0, 16'd0,     4'd0,  4'd0,  16'd3},     1'b0, '0},
      '{'{OP_BURST,  5'd1,  2'd0, 16'd0,     4'd0,  4'd1,  16'd2},     1'b0, '0},
      '{'{OP_BURST,  5'd1,  2'd0, 16'd0,     4'd0,  4'd2,  16'd1},     1'b0, '0},
      '{'{OP_HEADER, 5'd2,  2'd2, 16'd1,     4'd1,  4'd0,  16'd0},     1'b0, '0},
      '{'{OP_BURST,  5'd2,  2'd0, 16'd0,     4'd0,  4'd0,  16'd5},     1'b0, '0},
      '{'{OP_HEADER, 5'd3,  2'd1, 16'd0,     4'd1,  4'd0,  16'd0},     1'b0, '0},
      '{'{OP_BURST,  5'd3,  2'd0, 16'd0,     4'd0,  4'd0,  16'd4},     1'b0, '0},
      '{'{OP_TICK,   5'd0,  2'd0, 16'd0,     4'd0,  4'd0,  16'd0},     1'b0, '0},
      '{'{OP_TICK,   5'd0,  2'd0, 16'd0,     4'd0,  4'd0,  16'd0},     1'b0, '0},
      '{'{OP_TICK,   5'd0,  2'd0, 16'd0,     4'd0,  4'd0,  16'd0},     1'b0, '0},
      '{'{OP_TICK,   5'd0,  2'd0, 16'd0,     4'd0,  4'd0,  16'd0},     1'b0, '0},
      '{'{OP_TICK,   5'd0,  2'd0, 16'd0,     4'd0,  4'd0,  16'd0},     1'b0, '0},
      '{'{OP_TICK,   5'd0,  2'd0, 16'd0,     4'd0,  4'd0,  16'd0},     1'b0, '0},
      '{'{OP_TICK,   5'd0,  2'd0, 16'd0,     4'd0,  4'd0,  16'd0},     1'b0, '0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want, got, r);

    // random part: batches of processes, each run until the scheduler reports done
    cur_phase = -1;
    while (n_items < TARGET) begin
      phase = n_items * 4 / TARGET;
      if (phase != cur_phase) begin
        cur_phase = phase;
        settle();
        case (phase)
          0: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
            write_reg(CFG_Q0, 8'd1);
            write_reg(CFG_Q1, 8'd255);
          end
          1: begin
            send_idle_pct = 63;
            recv_stall_pct = 0;
            write_reg(CFG_Q0, 8'd255);
            write_reg(CFG_Q1, 8'd1);
          end
          2: begin
            send_idle_pct = 0;
            recv_stall_pct = 63;
            write_reg(CFG_Q0, 8'd0);   // zero slices act as one tick
            write_reg(CFG_Q1, 8'd0);
          end
          default: begin
            send_idle_pct = 23;
            recv_stall_pct = 23;
            write_reg(CFG_Q0, Q0_RESET);
            write_reg(CFG_Q1, Q1_RESET);
          end
        endcase
      end else if ($urandom_range(5) == 0) begin
        settle();
        write_reg(CFG_Q0, 8'($urandom_range(1, 255)));
        write_reg(CFG_Q1, 8'($urandom_range(1, 255)));
      end

      repeat (($urandom_range(7) == 0) ? $urandom_range(5, NPROC) : $urandom_range(1, 3))
        add_process();
      steps = 0;
      do begin
        if ($urandom_range(19) == 0) noise();
        if ($urandom_range(39) == 0) add_process();
        tick(got, r);
        steps++;
      end while (!(got && r.dn) && steps < 3000);
      // finished scheduler keeps repeating its last report
      repeat ($urandom_range(2)) tick(got, r);
    end

    settle();
    $display("run covered %0d items, %0d reports (%0d done), %0d processes finished",
             n_items, n_reports, n_done_reports, n_finished);
    $display("%0d register writes across four handshake pressure phases", n_cfg);
    if (n_errors == 0) begin
      $display("multilevel_feedback_queue_scheduler regression: pass");
    end else begin
      $display("multilevel_feedback_queue_scheduler regression: fail");
    end
    $finish;
  end

endmodule
